[hdl/npt_pkg.sv]
package npt_pkg;

  localparam int unsigned WIDTH = 32;
  localparam int unsigned CNT_W = $clog2(WIDTH);

  localparam logic [WIDTH-1:0] VAL_MAX   = {WIDTH{1'b1}};
  localparam logic [WIDTH-1:0] NUM_ONE   = WIDTH'(1);
  localparam logic [WIDTH-1:0] NUM_TWO   = WIDTH'(2);
  localparam logic [WIDTH-1:0] NUM_THREE = WIDTH'(3);
  localparam logic [WIDTH-1:0] NUM_FIVE  = WIDTH'(5);
  localparam logic [WIDTH-1:0] NUM_SIX   = WIDTH'(6);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MOD3,
    ST_LOW,
    ST_HIGH,
    ST_OUT
  } npt_state_e;

  typedef struct packed {
    logic             start;
    logic [WIDTH-1:0] dividend;
    logic [WIDTH-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [WIDTH-1:0] quot;
    logic [WIDTH-1:0] rem;
  } div_rsp_t;

endpackage

[hdl/npt_divider.sv]
module npt_divider
  import npt_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [WIDTH-1:0] quo_q, quo_d;
  logic [WIDTH-1:0] rem_q, rem_d;
  logic [WIDTH-1:0] dvs_q, dvs_d;
  logic [WIDTH:0]   trial;
  logic             fits;

  // restoring divide, one quotient bit per cycle
  assign trial = {rem_q, quo_q[WIDTH-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(WIDTH - 1);
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      if (fits) begin
        rem_d = WIDTH'(trial - {1'b0, dvs_q});
      end else begin
        rem_d = trial[WIDTH-1:0];
      end
      quo_d = {quo_q[WIDTH-2:0], fits};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

[hdl/next_prime_trial_division_core.sv]
// Next-prime core. Each input item carries one unsigned 32-bit value; the core
// returns one result item: value_is_prime_o (the value itself is prime),
// next_prime_o (smallest prime strictly above the value) and overflow_o (no
// such prime fits in 32 bits, next_prime_o is then 0; true for every value of
// 4294967291 or more). Primality is decided by trial division: values up to 3
// and even values are settled at once, then the value is divided by 3 and by
// the pairs 6k-1, 6k+1 while the divisor does not exceed the quotient. All
// divisions go through one shared restoring divider, one quotient bit per
// clock. Testing one candidate n takes up to about 2 + sqrt(n)/3 divisions;
// an item tests the value and then the candidates value+1, value+2 and so on
// until one is prime, so its cost is the sum over those candidates. The
// core takes one item at a time: stall is high from acceptance until the
// result item has been taken.
module next_prime_trial_division_core
  import npt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [WIDTH-1:0] value_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             value_is_prime_o,
  output logic [WIDTH-1:0] next_prime_o,
  output logic             overflow_o
);

  npt_state_e state_q, state_d;

  logic [WIDTH-1:0] n_q;        // number under test
  logic [WIDTH-1:0] d_q, d_d;   // current 6k-1 divisor
  logic             first_q;    // testing the input value itself
  logic             is_prime_q;
  logic [WIDTH-1:0] next_prime_q;
  logic             ovf_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic verdict_v;  // primality of n_q settled this cycle
  logic verdict_p;
  logic finish;     // item done after this verdict
  logic in_acc;

  npt_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_acc = in_valid_i && !in_stall_o;

  // trial-division step decisions
  always_comb begin
    div_req          = '0;
    div_req.dividend = n_q;
    verdict_v        = 1'b0;
    verdict_p        = 1'b0;
    d_d              = d_q;
    unique case (state_q)
      ST_CHECK: begin
        if (n_q <= NUM_ONE) begin
          verdict_v = 1'b1;
        end else if (n_q <= NUM_THREE) begin
          verdict_v = 1'b1;
          verdict_p = 1'b1;
        end else if (!n_q[0]) begin
          verdict_v = 1'b1;
        end else begin
          div_req.start   = 1'b1;
          div_req.divisor = NUM_THREE;
        end
      end
      ST_MOD3: begin
        if (div_rsp.done) begin
          if (div_rsp.rem == '0) begin
            verdict_v = 1'b1;
          end else begin
            d_d             = NUM_FIVE;
            div_req.start   = 1'b1;
            div_req.divisor = NUM_FIVE;
          end
        end
      end
      ST_LOW: begin
        if (div_rsp.done) begin
          // d > n/d means d*d > n: no divisor left
          if (d_q > div_rsp.quot) begin
            verdict_v = 1'b1;
            verdict_p = 1'b1;
          end else if (div_rsp.rem == '0) begin
            verdict_v = 1'b1;
          end else begin
            div_req.start   = 1'b1;
            div_req.divisor = d_q + NUM_TWO;
          end
        end
      end
      ST_HIGH: begin
        if (div_rsp.done) begin
          if (div_rsp.rem == '0) begin
            verdict_v = 1'b1;
          end else begin
            d_d             = d_q + NUM_SIX;
            div_req.start   = 1'b1;
            div_req.divisor = d_d;
          end
        end
      end
      default: ;
    endcase
  end

  assign finish = (!first_q && verdict_p) || (n_q == VAL_MAX);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) state_d = ST_CHECK;
      end
      ST_CHECK, ST_MOD3, ST_LOW, ST_HIGH: begin
        if (verdict_v) begin
          state_d = finish ? ST_OUT : ST_CHECK;
        end else if (div_req.start) begin
          unique case (state_q)
            ST_CHECK: state_d = ST_MOD3;
            ST_MOD3:  state_d = ST_LOW;
            ST_LOW:   state_d = ST_HIGH;
            default:  state_d = ST_LOW;
          endcase
        end
      end
      ST_OUT: begin
        if (!out_stall_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_stall_o  = (state_q != ST_IDLE);
    out_valid_o = (state_q == ST_OUT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      first_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        first_q <= 1'b1;
      end else if (verdict_v) begin
        first_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    d_q <= d_d;
    if (in_acc) begin
      n_q <= value_i;
    end else if (verdict_v) begin
      if (first_q) is_prime_q <= verdict_p;
      if (!first_q && verdict_p) begin
        next_prime_q <= n_q;
        ovf_q        <= 1'b0;
      end else if (n_q == VAL_MAX) begin
        next_prime_q <= '0;
        ovf_q        <= 1'b1;
      end else begin
        n_q <= n_q + NUM_ONE;
      end
    end
  end

  assign value_is_prime_o = is_prime_q;
  assign next_prime_o     = next_prime_q;
  assign overflow_o       = ovf_q;

  // the core never takes an item while a result is pending
  a_busy_on_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while result pending");

  // overflow results carry a zero prime
  a_ovf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && overflow_o) |-> (next_prime_o == '0))
    else $error("overflow with nonzero next prime");

  // divider completes only while the sequencer waits on it
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_MOD3 || state_q == ST_LOW || state_q == ST_HIGH))
    else $error("divider done outside a wait state");

  // an accepted item starts with the trivial checks on the value itself
  a_accept_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_CHECK && first_q))
    else $error("accepted item not under test");

endmodule

[sim/next_prime_checker.sv]
`timescale 1ns / 1ps

module next_prime_checker
  import npt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  logic [WIDTH-1:0] value_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  logic             value_is_prime_i,
  input  logic [WIDTH-1:0] next_prime_i,
  input  logic             overflow_i,
  output int unsigned      err_count_o,
  output int unsigned      pending_o
);

  typedef struct {
    logic             is_prime;
    logic [WIDTH-1:0] next;
    logic             ovf;
  } prime_answer_t;

  prime_answer_t answers_q[$];
  int unsigned   err_count = 0;

  assign err_count_o = err_count;

  // trial division by 2, 3, then 6k-1 / 6k+1 while d <= n / d
  function automatic logic is_prime_trial(input logic [WIDTH-1:0] n);
    logic [WIDTH-1:0] d;
    if (n <= NUM_ONE) return 1'b0;
    if (n <= NUM_THREE) return 1'b1;
    if (n % NUM_TWO == 0 || n % NUM_THREE == 0) return 1'b0;
    for (d = NUM_FIVE; d <= n / d; d = d + NUM_SIX) begin
      if (n % d == 0 || n % (d + NUM_TWO) == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic prime_answer_t predict_answer(input logic [WIDTH-1:0] v);
    prime_answer_t    a;
    logic [WIDTH-1:0] cand;
    a.is_prime = is_prime_trial(v);
    a.next     = '0;
    a.ovf      = 1'b1;
    cand       = v;
    while (cand < VAL_MAX) begin
      cand = cand + NUM_ONE;
      if (is_prime_trial(cand)) begin
        a.next = cand;
        a.ovf  = 1'b0;
        break;
      end
    end
    return a;
  endfunction

  task automatic report_mismatch(input string what, input logic [WIDTH-1:0] got,
                                 input logic [WIDTH-1:0] want);
    $display("ERROR @%0t: %s: got %0d, expected %0d", $time, what, got, want);
    err_count++;
  endtask

  always @(posedge clk_i) begin : watch
    prime_answer_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) answers_q.push_back(predict_answer(value_i));
      if (out_valid_i && !out_stall_i) begin
        if (answers_q.size() == 0) begin
          report_mismatch("result item with nothing expected, next_prime",
                          next_prime_i, '0);
        end else begin
          want = answers_q.pop_front();
          if (value_is_prime_i !== want.is_prime)
            report_mismatch("value_is_prime", WIDTH'(value_is_prime_i),
                            WIDTH'(want.is_prime));
          if (next_prime_i !== want.next)
            report_mismatch("next_prime", next_prime_i, want.next);
          if (overflow_i !== want.ovf)
            report_mismatch("overflow", WIDTH'(overflow_i), WIDTH'(want.ovf));
        end
      end
      pending_o <= answers_q.size();
    end else begin
      pending_o <= 0;
    end
  end

endmodule

[sim/next_prime_trial_division_core_tb.sv]
`timescale 1ns / 1ps

module next_prime_trial_division_core_tb;
  import npt_pkg::*;

  // no-handshake cycles before giving up; set far above the slowest directed
  // item (largest 32-bit prime) and every other item
  localparam int unsigned IDLE_LIMIT   = 8_000_000;
  localparam int unsigned HOLD_CYCLES  = 3000;
  localparam int unsigned RANDOM_ITEMS = 75;
  localparam int unsigned DRAIN_CYCLES = 50;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY
  } stall_mode_e;

  logic             clk            = 1'b0;
  logic             rst_n          = 1'b0;
  logic             in_valid       = 1'b0;
  logic             in_stall;
  logic [WIDTH-1:0] value          = '0;
  logic             out_valid;
  logic             out_stall      = 1'b0;
  logic             value_is_prime;
  logic [WIDTH-1:0] next_prime;
  logic             overflow;

  logic             hold_off       = 1'b0;
  stall_mode_e      stall_mode     = STALL_NONE;
  int unsigned      stall_phase    = 0;
  int unsigned      results_taken  = 0;
  int unsigned      idle_cycles    = 0;
  int unsigned      burst_left     = 0;
  int unsigned      err_count;
  int unsigned      pending;

  always #2 clk = ~clk;

  next_prime_trial_division_core dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .value_i          (value),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .value_is_prime_o (value_is_prime),
    .next_prime_o     (next_prime),
    .overflow_o       (overflow)
  );

  next_prime_checker checker_i (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .value_i          (value),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .value_is_prime_i (value_is_prime),
    .next_prime_i     (next_prime),
    .overflow_i       (overflow),
    .err_count_o      (err_count),
    .pending_o        (pending)
  );

  // Receiver: stall behavior switches between modes each time the random phase
  // counter runs out, so there are runs with no stall at all and runs of heavy
  // stalling. hold_off forces stall high regardless of mode.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall   <= 1'b0;
      stall_mode  <= STALL_NONE;
      stall_phase <= 0;
    end else begin
      if (stall_phase == 0) begin
        stall_mode  <= stall_mode_e'($urandom_range(0, 2));
        stall_phase <= $urandom_range(16, 96);
      end else begin
        stall_phase <= stall_phase - 1;
      end
      case (stall_mode)
        STALL_NONE:  out_stall <= hold_off;
        STALL_LIGHT: out_stall <= hold_off | ($urandom_range(0, 3) == 0);
        default:     out_stall <= hold_off | ($urandom_range(0, 9) < 6);
      endcase
    end
  end

  // Long hold-off once the run is under way: the core finishes its item,
  // the result sits unaccepted, and in_stall stays up while items keep
  // being offered.
  initial begin : receiver_hold
    wait (results_taken >= 20);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Watchdog: any handshake on either side clears the idle count.
  always @(posedge clk) begin
    if (out_valid && !out_stall) results_taken <= results_taken + 1;
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Offer one item and hold it until accepted. Bursts of back-to-back items
  // are separated by random gaps; valid is only dropped when a gap follows,
  // so a continuing burst never lowers and re-raises it in one step.
  task automatic offer_value(input logic [WIDTH-1:0] v);
    int unsigned gap;
    value    <= v;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 7);
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 3000)
                                         : $urandom_range(0, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Random values: mostly small since cost grows with sqrt of each candidate
  // tested; a few wider ones, and some at the very top where no prime fits.
  function automatic logic [WIDTH-1:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 55)      return $urandom_range(0, 1023);
    else if (sel < 80) return $urandom_range(0, 65535);
    else if (sel < 92) return $urandom & 32'h000F_FFFF;
    else if (sel < 94) return $urandom & 32'h00FF_FFFF;
    else               return VAL_MAX - $urandom_range(0, 3);
  endfunction

  logic [WIDTH-1:0] directed_values[] = '{
    // below 2, the two small primes, first values past the early exits
    0, 1, 2, 3, 4, 5, 6, 8, 9,
    // prime gaps and squares that only the 6k-1 / 6k+1 divisors catch
    13, 23, 24, 25, 35, 48, 89, 120, 121, 168, 1000,
    // largest 16-bit prime and all-ones 16-bit
    65521, 65535,
    // largest 32-bit prime: full-length divisor loop, then overflow
    32'd4294967291,
    // overflow region, including all ones
    32'd4294967292, 32'd4294967295
  };

  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_values[i]) offer_value(directed_values[i]);
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) offer_value(pick_value());
    in_valid <= 1'b0;

    // let the last accepted item reach the checker, then drain
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/npt_pkg.sv
hdl/npt_divider.sv
hdl/next_prime_trial_division_core.sv
sim/next_prime_checker.sv
sim/next_prime_trial_division_core_tb.sv
